// ----- sv/rwlf_pkg.sv -----
// Shared phase codes, event codes and the step decision type for the worker lifecycle block.
package rwlf_pkg;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_STARTING = 3'd1;
  localparam logic [2:0] PH_ARMED    = 3'd2;
  localparam logic [2:0] PH_RUNNING  = 3'd3;
  localparam logic [2:0] PH_STOPPING = 3'd4;
  localparam logic [2:0] PH_REAPABLE = 3'd5;
  localparam logic [2:0] PH_FATAL    = 3'd6;

  localparam logic [2:0] REQ_BEGIN   = 3'd0;
  localparam logic [2:0] REQ_READY   = 3'd1;
  localparam logic [2:0] REQ_STARTED = 3'd2;
  localparam logic [2:0] REQ_STOP    = 3'd3;
  localparam logic [2:0] REQ_DONE    = 3'd4;
  localparam logic [2:0] REQ_REAP    = 3'd5;
  localparam logic [2:0] REQ_FATAL   = 3'd6;
  localparam logic [2:0] REQ_STATUS  = 3'd7;

  localparam int STREAM_W = 64;
  localparam int GEN_W    = 32;
  localparam int OUT_CNT_W = 32;

  // Decision for one event, produced by the step logic and applied by the top level.
  typedef struct packed {
    logic       accepted;
    logic [2:0] phase_nxt;
    logic       gen_bump;
    logic       load_active;
    logic       clear_active;
    logic       store_done;
    logic       clear_result;
    logic       inc_dup;
    logic       inc_stale;
  } rwlf_step_t;

endpackage

// ----- sv/rx_worker_lifecycle_fsm_core.sv -----
// Top level of the receive worker lifecycle controller: input register, state and result.
// The input register loads the word when it is accepted; the state update, which doubles as the
// result register, then takes the decoded word and presents the result.
// Throughput: one word per cycle while out_stall is low; the decode between the input register
// and the state registers is combinational, and the two stages move whenever the result slot is empty or taken.
// Reset (rst_n low, synchronous): phase idle, generation, counters and stream fields zero.
module rx_worker_lifecycle_fsm_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [63:0] in_stream_id,
  input  logic [63:0] in_worker_result,
  input  logic        in_other_worker_started,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [2:0]  out_phase,
  output logic        out_busy_res,
  output logic        out_legacy_start_ok,
  output logic [31:0] out_generation_out,
  output logic [31:0] out_transitions_out,
  output logic [31:0] out_duplicate_stops_out,
  output logic [31:0] out_stale_events_out,
  output logic [63:0] out_active_stream_out,
  output logic [63:0] out_completed_stream_out,
  output logic [63:0] out_result_out
);

  // Input register. A word waits here until the result side has room for its answer.
  logic        iv_r;
  logic [2:0]  req_r;
  logic [63:0] sid_r;
  logic [63:0] wres_r;
  logic        other_r;

  // State. The state registers change only when a new result is produced, and that can only
  // happen once the previous result has been taken, so while a result waits the state still
  // shows exactly the status after that word. The state registers therefore serve directly as
  // the payload of the result; only the accepted flag and the legacy check need their own bits.
  logic [2:0]                       phase_r;
  logic [rwlf_pkg::GEN_W-1:0]       gen_r;
  logic [COUNT_BITS-1:0]            trans_r;
  logic [COUNT_BITS-1:0]            dup_r;
  logic [COUNT_BITS-1:0]            stale_r;
  logic [rwlf_pkg::STREAM_W-1:0]    active_r;
  logic [rwlf_pkg::STREAM_W-1:0]    completed_r;
  logic [rwlf_pkg::STREAM_W-1:0]    result_r;

  logic ov_r;
  logic acc_r;
  logic legacy_r;

  logic                       advance;
  logic                       fire;
  rwlf_pkg::rwlf_step_t       step;
  logic [rwlf_pkg::GEN_W-1:0] gen_inc;
  logic [rwlf_pkg::GEN_W-1:0] gen_nxt;
  logic [63:0]                trans_ext;
  logic [63:0]                dup_ext;
  logic [63:0]                stale_ext;

  // The result slot is free when empty or being taken in this cycle.
  assign advance  = !ov_r || !out_stall;
  assign fire     = iv_r && advance;
  assign in_stall = iv_r && !advance;

  rwlf_step u_step (
    .req_type      (req_r),
    .evt_sid       (sid_r),
    .phase         (phase_r),
    .active_stream (active_r),
    .step          (step)
  );

  // Generation wraps but skips zero, so a live session never carries generation zero.
  assign gen_inc = gen_r + rwlf_pkg::GEN_W'(1);
  assign gen_nxt = (gen_inc == '0) ? rwlf_pkg::GEN_W'(1) : gen_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (!in_stall) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r   <= in_req_type;
      sid_r   <= in_stream_id;
      wres_r  <= in_worker_result;
      other_r <= in_other_worker_started;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r        <= 1'b0;
      acc_r       <= 1'b0;
      legacy_r    <= 1'b0;
      phase_r     <= rwlf_pkg::PH_IDLE;
      gen_r       <= '0;
      trans_r     <= '0;
      dup_r       <= '0;
      stale_r     <= '0;
      active_r    <= '0;
      completed_r <= '0;
      result_r    <= '0;
    end else begin
      if (advance) begin
        ov_r <= iv_r;
      end
      if (fire) begin
        acc_r    <= step.accepted;
        legacy_r <= (step.phase_nxt == rwlf_pkg::PH_IDLE) && !other_r;
        phase_r  <= step.phase_nxt;
        if (step.gen_bump) begin
          gen_r <= gen_nxt;
        end
        if (step.accepted) begin
          trans_r <= trans_r + COUNT_BITS'(1);
        end
        if (step.inc_dup) begin
          dup_r <= dup_r + COUNT_BITS'(1);
        end
        if (step.inc_stale) begin
          stale_r <= stale_r + COUNT_BITS'(1);
        end
        if (step.load_active) begin
          active_r <= sid_r;
        end else if (step.clear_active) begin
          active_r <= '0;
        end
        if (step.store_done) begin
          completed_r <= sid_r;
          result_r    <= wres_r;
        end else if (step.clear_result) begin
          result_r <= '0;
        end
      end
    end
  end

  // The event counters may be narrower or wider than the 32-bit status fields.
  assign trans_ext = 64'(trans_r);
  assign dup_ext   = 64'(dup_r);
  assign stale_ext = 64'(stale_r);

  assign out_valid                = ov_r;
  assign out_accepted             = acc_r;
  assign out_phase                = phase_r;
  assign out_busy_res             = (phase_r != rwlf_pkg::PH_IDLE);
  assign out_legacy_start_ok      = legacy_r;
  assign out_generation_out       = gen_r;
  assign out_transitions_out      = trans_ext[rwlf_pkg::OUT_CNT_W-1:0];
  assign out_duplicate_stops_out  = dup_ext[rwlf_pkg::OUT_CNT_W-1:0];
  assign out_stale_events_out     = stale_ext[rwlf_pkg::OUT_CNT_W-1:0];
  assign out_active_stream_out    = active_r;
  assign out_completed_stream_out = completed_r;
  assign out_result_out           = result_r;

  // Fatal is left only by reset.
  a_fatal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rwlf_pkg::PH_FATAL) |=> (phase_r == rwlf_pkg::PH_FATAL))
    else $error("fatal phase was left without reset");

  // Any phase inside a session was entered through begin, so it has a generation and a stream.
  a_session_has_stream: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == rwlf_pkg::PH_STARTING) || (phase_r == rwlf_pkg::PH_ARMED) ||
     (phase_r == rwlf_pkg::PH_RUNNING) || (phase_r == rwlf_pkg::PH_STOPPING) ||
     (phase_r == rwlf_pkg::PH_REAPABLE)) |-> ((gen_r != '0) && (active_r != '0)))
    else $error("session phase without generation or stream");

  // An accepted event steps the transition counter by exactly one.
  a_trans_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && step.accepted) |=> (trans_r == $past(trans_r) + COUNT_BITS'(1)))
    else $error("transition counter did not follow an accepted event");

  // While a result waits, the state behind it must not move.
  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ($stable(phase_r) && $stable(trans_r) && $stable(active_r)))
    else $error("status changed while result was stalled");

endmodule

// ----- sv/rwlf_step.sv -----
// Event decode: decides the transition and the side effects of one event.
module rwlf_step (
  input  logic [2:0]                     req_type,
  input  logic [rwlf_pkg::STREAM_W-1:0]  evt_sid,
  input  logic [2:0]                     phase,
  input  logic [rwlf_pkg::STREAM_W-1:0]  active_stream,
  output rwlf_pkg::rwlf_step_t           step
);

  logic in_session;
  logic sid_ok;
  logic done_ok;

  assign in_session = (phase == rwlf_pkg::PH_STARTING) || (phase == rwlf_pkg::PH_ARMED) ||
                      (phase == rwlf_pkg::PH_RUNNING);
  assign sid_ok     = (evt_sid != '0);
  assign done_ok    = sid_ok && (evt_sid == active_stream) &&
                      (in_session || (phase == rwlf_pkg::PH_STOPPING));

  always_comb begin
    step = '0;
    step.phase_nxt = phase;
    unique case (req_type)
      rwlf_pkg::REQ_BEGIN: begin
        if ((phase == rwlf_pkg::PH_IDLE) && sid_ok) begin
          step.accepted     = 1'b1;
          step.phase_nxt    = rwlf_pkg::PH_STARTING;
          step.gen_bump     = 1'b1;
          step.load_active  = 1'b1;
          step.clear_result = 1'b1;
        end
      end
      rwlf_pkg::REQ_READY: begin
        if (phase == rwlf_pkg::PH_STARTING) begin
          step.accepted  = 1'b1;
          step.phase_nxt = rwlf_pkg::PH_ARMED;
        end
      end
      rwlf_pkg::REQ_STARTED: begin
        if (phase == rwlf_pkg::PH_ARMED) begin
          step.accepted  = 1'b1;
          step.phase_nxt = rwlf_pkg::PH_RUNNING;
        end
      end
      rwlf_pkg::REQ_STOP: begin
        if (phase == rwlf_pkg::PH_STOPPING) begin
          step.inc_dup = 1'b1;
        end else if (in_session) begin
          step.accepted  = 1'b1;
          step.phase_nxt = rwlf_pkg::PH_STOPPING;
        end
      end
      rwlf_pkg::REQ_DONE: begin
        if (done_ok) begin
          step.accepted   = 1'b1;
          step.phase_nxt  = rwlf_pkg::PH_REAPABLE;
          step.store_done = 1'b1;
        end else begin
          step.inc_stale = 1'b1;
        end
      end
      rwlf_pkg::REQ_REAP: begin
        if (phase == rwlf_pkg::PH_REAPABLE) begin
          step.accepted     = 1'b1;
          step.phase_nxt    = rwlf_pkg::PH_IDLE;
          step.clear_active = 1'b1;
        end
      end
      rwlf_pkg::REQ_FATAL: begin
        step.accepted  = 1'b1;
        step.phase_nxt = rwlf_pkg::PH_FATAL;
      end
      rwlf_pkg::REQ_STATUS: begin
        step.accepted = 1'b0;
      end
      default: begin
        step.accepted = 1'b0;
      end
    endcase
  end

endmodule
